FILE: src/mctw_pkg.sv
// Shared types and constants for the multi-channel task watchdog.
package mctw_pkg;

  localparam int Entries = 16;
  localparam int IdxW = $clog2(Entries);
  localparam int CntW = $clog2(Entries + 1);

  localparam logic [2:0] ActRegister = 3'd0;
  localparam logic [2:0] ActUnregister = 3'd1;
  localparam logic [2:0] ActFeed = 3'd2;
  localparam logic [2:0] ActPause = 3'd3;
  localparam logic [2:0] ActResume = 3'd4;
  localparam logic [2:0] ActSetDeadline = 3'd5;
  localparam logic [2:0] ActQuery = 3'd6;
  localparam logic [2:0] ActTick = 3'd7;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StBad = 2'd1;
  localparam logic [1:0] StDup = 2'd2;
  localparam logic [1:0] StFull = 2'd3;

  localparam logic [1:0] HkOwn = 2'd0;
  localparam logic [1:0] HkDefault = 2'd1;
  localparam logic [1:0] HkHalt = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  task_id;
    logic [31:0] deadline;
    logic        own_handler;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  event_task;
    logic        timed_out;
    logic [1:0]  handler_kind;
    logic [31:0] remaining_ticks;
    logic        is_registered;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [31:0] reload;
    logic [31:0] left;
    logic        paused;
    logic        own_handler;
  } entry_t;

endpackage

FILE: src/multi_channel_task_watchdog_unit.sv
// Top level of the multi-channel task watchdog: sequencer around the entry table.
// Words are handled one at a time and the table is walked slot by slot, each slot
// read and then checked. Unregister adds a step that reads the last occupied slot;
// a non-tick word with a null id is answered without walking the table.
// A tick offers one word per expired entry, or a single OK word if none expired,
// and the next word can be taken in the cycle after its final word is accepted.
// Synchronous reset empties the table and clears the handler setting.
module multi_channel_task_watchdog_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mctw_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mctw_pkg::out_word_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);
  import mctw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CHECK, S_LAST, S_MOVE, S_OUT
  } state_t;

  state_t state;
  in_word_t cur;
  logic [CntW-1:0] count;
  logic [CntW-1:0] idx;
  logic [IdxW-1:0] hit;
  logic found;
  logic any_out;
  logic dflt;
  logic done_after;
  out_word_t pend;
  out_word_t pend_last;
  out_word_t exp_word;
  out_word_t move_word;

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t wdata, rdata;

  entry_t   upd;
  logic     upd_we;
  logic [IdxW-1:0] upd_addr;
  entry_t   hold;

  logic tbl_we;
  logic [IdxW-1:0] tbl_waddr;
  entry_t tbl_wdata;

  mctw_table u_table (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata), .raddr(raddr),
    .rdata(rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  logic [31:0] dec;
  logic tick_live, expire;
  assign tick_live = !rdata.paused && rdata.task_id != 8'd0;
  assign dec = (rdata.left != 32'd0) ? rdata.left - 32'd1 : 32'd0;
  assign expire = tick_live && dec == 32'd0;

  always_comb begin
    we = 1'b0;
    waddr = idx[IdxW-1:0];
    wdata = rdata;
    raddr = idx[IdxW-1:0];
    if (state == S_CHECK && cur.action == ActTick && idx < count && tick_live) begin
      we = 1'b1;
      wdata.left = expire ? rdata.reload : dec;
    end
    if (state == S_LAST) begin
      raddr = IdxW'(count - CntW'(1));
    end
  end

  function automatic out_word_t simple(input logic [1:0] st);
    out_word_t o;
    o = '0;
    o.status = st;
    o.last = 1'b1;
    return o;
  endfunction

  always_comb begin
    exp_word = '0;
    exp_word.event_task = rdata.task_id;
    exp_word.timed_out = 1'b1;
    exp_word.handler_kind = rdata.own_handler ? HkOwn : (dflt ? HkDefault : HkHalt);
  end

  always_comb begin
    pend_last = pend;
    pend_last.last = 1'b1;
  end

  always_comb begin
    move_word = simple(StOk);
    case (cur.action)
      ActRegister: begin
        if (cur.deadline == 32'd0) move_word = simple(StBad);
        else if (found) move_word = simple(StDup);
        else if (count == CntW'(Entries)) move_word = simple(StFull);
      end
      ActSetDeadline: begin
        if (!found || cur.deadline == 32'd0) move_word = simple(StBad);
      end
      ActQuery: begin
        if (!found) move_word = simple(StBad);
        else begin
          move_word.remaining_ticks = hold.left;
          move_word.is_registered = 1'b1;
        end
      end
      default: begin
        if (!found) move_word = simple(StBad);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      dflt <= 1'b0;
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (cfg_valid) begin
        dflt <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur <= in_data;
            idx <= '0;
            found <= 1'b0;
            any_out <= 1'b0;
            if (in_data.action != ActTick && in_data.task_id == 8'd0) begin
              out_data <= simple(StBad);
              out_valid <= 1'b1;
              state <= S_OUT;
              done_after <= 1'b1;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (cur.action == ActTick) begin
            if (idx >= count) begin
              out_data <= any_out ? pend_last : simple(StOk);
              out_valid <= 1'b1;
              done_after <= 1'b1;
              state <= S_OUT;
            end else if (expire) begin
              pend <= exp_word;
              any_out <= 1'b1;
              if (any_out) begin
                out_data <= pend;
                out_valid <= 1'b1;
                done_after <= 1'b0;
                state <= S_OUT;
              end else begin
                idx <= idx + CntW'(1);
                state <= S_READ;
              end
            end else begin
              idx <= idx + CntW'(1);
              state <= S_READ;
            end
          end else if (idx < count && rdata.task_id != cur.task_id) begin
            if (idx == count - CntW'(1)) begin
              idx <= count;
              state <= S_CHECK;
            end else begin
              idx <= idx + CntW'(1);
              state <= S_READ;
            end
          end else begin
            found <= idx < count;
            hit <= idx[IdxW-1:0];
            if (idx < count && cur.action == ActUnregister) begin
              state <= S_LAST;
            end else begin
              state <= S_MOVE;
            end
          end
        end
        S_LAST: begin
          state <= S_MOVE;
        end
        S_MOVE: begin
          out_valid <= 1'b1;
          done_after <= 1'b1;
          state <= S_OUT;
          out_data <= move_word;
          if (cur.action == ActRegister && upd_we) begin
            count <= count + CntW'(1);
          end else if (cur.action == ActUnregister && found) begin
            count <= count - CntW'(1);
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (done_after) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + CntW'(1);
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Updates decided in S_MOVE share the single table write port with the tick walk.
  always_ff @(posedge clk) begin
    if (state == S_CHECK) hold <= rdata;
  end

  always_comb begin
    upd_we = 1'b0;
    upd_addr = hit;
    upd = hold;
    if (state == S_MOVE) begin
      case (cur.action)
        ActRegister: begin
          upd_addr = IdxW'(count);
          upd.task_id = cur.task_id;
          upd.reload = cur.deadline;
          upd.left = cur.deadline;
          upd.paused = 1'b0;
          upd.own_handler = cur.own_handler;
          upd_we = cur.deadline != 32'd0 && !found && count != CntW'(Entries);
        end
        ActUnregister: begin
          upd = rdata;
          upd_we = found;
        end
        ActFeed: begin
          upd.left = hold.reload;
          upd_we = found;
        end
        ActPause: begin
          upd.paused = 1'b1;
          upd_we = found;
        end
        ActResume: begin
          upd.paused = 1'b0;
          upd.left = hold.reload;
          upd_we = found;
        end
        ActSetDeadline: begin
          upd.reload = cur.deadline;
          upd.left = cur.deadline;
          upd_we = found && cur.deadline != 32'd0;
        end
        default: upd_we = 1'b0;
      endcase
    end
  end

  assign tbl_we = we || upd_we;
  assign tbl_waddr = upd_we ? upd_addr : waddr;
  assign tbl_wdata = upd_we ? upd : wdata;

  assert property (@(posedge clk) disable iff (rst) count <= CntW'(Entries))
    else $error("entry count beyond table size");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    !(we && upd_we))
    else $error("two table writes in one cycle");
endmodule

FILE: src/mctw_table.sv
// Entry table memory with one write port and one registered read port.
module mctw_table (
  input  logic                  clk,
  input  logic                  we,
  input  logic [mctw_pkg::IdxW-1:0] waddr,
  input  mctw_pkg::entry_t      wdata,
  input  logic [mctw_pkg::IdxW-1:0] raddr,
  output mctw_pkg::entry_t      rdata
);
  import mctw_pkg::*;

  entry_t mem [Entries];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
